// File: hw/rtl/median_filter_window_unit_assert.svh
// Assertion macros used by the median filter top level.
`ifndef MEDIAN_FILTER_WINDOW_UNIT_ASSERT_SVH
`define MEDIAN_FILTER_WINDOW_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge, disabled while in reset.
`define MFW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define MFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/mfw_pkg.sv
// Package with the constants and types of the median filter.
`default_nettype none
package mfw_pkg;
	localparam int MaxLine  = 2048;
	localparam int WinSize  = 5;
	localparam int HistRows = WinSize - 1;
	localparam int WinArea  = WinSize * WinSize;
	localparam int ColW     = $clog2(MaxLine);
	localparam int AddrW    = $clog2(MaxLine);
	localparam int WidthW   = 12;
	localparam int PixW     = 8;
	localparam int EntryW   = HistRows * PixW;
	localparam int RowW     = 3;
	localparam logic [WidthW-1:0] WidthReset = WidthW'(640);

	typedef logic [PixW-1:0]   pix_t;
	typedef logic [EntryW-1:0] entry_t;

	// Control flags of a window column, carried along with it through the pipeline stages.
	typedef struct packed {
		logic emit;
		logic last;
	} col_ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/median_filter_window_unit.sv
// Top level of the streaming 5x5 median filter with line store memory.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------
//  input    | in_valid/in_stall | pixel, frame_start
//  output   | out_valid/out_stall | median_value, row_end
//  config   | cfg_valid/cfg_ready | cfg_data (line_width)
//
// One pixel is taken per clock unless a held result stalls the pipeline; each result
// passes stages s1 to s4. The rate rests on a two-port read-modify-write of the line
// store memory, with the entry written in the previous cycle forwarded.
// Reset clears counters and valid flags; the line store is not cleared.
// A valid result held by out_stall stops the whole pipeline; input is held off only then.
`default_nettype none
module median_filter_window_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire logic [mfw_pkg::PixW-1:0]   pixel,
	input  wire logic                       frame_start,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic [mfw_pkg::PixW-1:0]   median_value,
	output      logic                       row_end,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [mfw_pkg::WidthW-1:0] cfg_data
);
	import mfw_pkg::*;
`include "median_filter_window_unit_assert.svh"

	logic [WidthW-1:0] width_q;
	logic [ColW-1:0]   col_q;
	logic [RowW-1:0]   row_q;
	entry_t            mem [MaxLine];
	entry_t            rd_s2;
	logic              v_s1, v_s2, v_s3, v_s4;
	pix_t              px_s1;
	logic [AddrW-1:0]  addr_s1;
	col_ctl_t          ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	pix_t              px_s2;
	logic [AddrW-1:0]  addr_s2;
	logic              fwd_s2;
	entry_t            wdata_q;
	entry_t            entry;
	pix_t [WinSize-1:0][WinSize-1:0] win_q;
	logic [WinArea*PixW-1:0] win_flat;
	logic              adv;
	logic              acc;
	logic [ColW:0]     wlast;
	logic [ColW-1:0]   col_cur;
	logic [RowW-1:0]   row_cur;
	logic              last;

	// Whole pipeline moves unless a finished result is held.
	assign adv       = !(v_s4 && out_stall);
	assign in_stall  = !adv;
	assign acc       = in_valid && adv;
	assign cfg_ready = 1'b1;

	// Effective width minus one, saturated to the legal range.
	always_comb begin
		if (width_q < WidthW'(WinSize))
			wlast = (ColW+1)'(WinSize - 1);
		else if (width_q > WidthW'(MaxLine))
			wlast = (ColW+1)'(MaxLine - 1);
		else
			wlast = (ColW+1)'(width_q - 1'b1);
		col_cur = frame_start ? '0 : col_q;
		row_cur = frame_start ? '0 : row_q;
		last    = {1'b0, col_cur} >= wlast;
	end

	// Register and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WidthReset;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cfg_valid) width_q <= cfg_data;
			if (acc) begin
				col_q <= last ? '0 : col_cur + 1'b1;
				if (last && row_cur < RowW'(HistRows)) row_q <= row_cur + 1'b1;
				else row_q <= row_cur;
			end
		end
	end

	// Valid flags of the pipeline stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc; v_s2 <= v_s1; v_s3 <= v_s2 && ctl_s2.emit;
			v_s4 <= v_s3;
		end
	end

	// Stage one registers the beat; stage two takes it on with the line store entry it reads.
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1      <= pixel;
			addr_s1    <= col_cur;
			ctl_s1.emit <= row_cur >= RowW'(HistRows) && col_cur >= ColW'(HistRows);
			ctl_s1.last <= last;
			rd_s2      <= mem[addr_s1];
			fwd_s2     <= v_s1 && v_s2 && (addr_s1 == addr_s2);
			px_s2      <= px_s1;
			addr_s2    <= addr_s1;
			ctl_s2     <= ctl_s1;
		end
	end

	// Forward the entry written last cycle when the same column is read back.
	assign entry = fwd_s2 ? wdata_q : rd_s2;

	// Stage two writes back the entry and shifts the window.
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			mem[addr_s2] <= {px_s2, entry[EntryW-1:PixW]};
			wdata_q      <= {px_s2, entry[EntryW-1:PixW]};
			for (int r = 0; r < WinSize; r++) begin
				for (int c = 0; c < WinSize - 1; c++) win_q[r][c] <= win_q[r][c+1];
			end
			for (int k = 0; k < HistRows; k++)
				win_q[k][WinSize-1] <= entry[k*PixW +: PixW];
			win_q[WinSize-1][WinSize-1] <= px_s2;
		end
		if (adv) begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	assign win_flat = win_q;

	mfw_median u_med (
		.clk   (clk),
		.en    (adv),
		.win   (win_flat),
		.med   (median_value)
	);

	assign out_valid = v_s4;
	assign row_end   = ctl_s4.last;

	`MFW_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped")
	`MFW_ASSERT_IMP(a_stall, clk, arst_n, in_stall, out_valid && out_stall, "stall without cause")
	`MFW_ASSERT_IMP(a_row, clk, arst_n, 1'b1, row_q <= RowW'(HistRows), "row count overflow")
endmodule
`default_nettype wire

// File: hw/rtl/mfw_median.sv
// Pipelined median of a 5x5 window, built from rank counting in two stages.
`default_nettype none
module mfw_median (
	input  wire logic                                   clk,
	input  wire logic                                   en,
	input  wire logic [mfw_pkg::WinArea*mfw_pkg::PixW-1:0] win,
	output      logic [mfw_pkg::PixW-1:0]               med
);
	import mfw_pkg::*;

	localparam int CntW = $clog2(WinArea + 1);
	localparam int Mid  = (WinArea - 1) / 2;

	logic [WinArea-1:0][WinArea-1:0] lt_s1;
	logic [WinArea-1:0][WinArea-1:0] eq_s1;
	pix_t [WinArea-1:0]              val_s1;
	logic [WinArea-1:0]              hit;
	pix_t                            pick;

	// First stage: compare every pair of window pixels.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < WinArea; i++) begin
				val_s1[i] <= win[i*PixW +: PixW];
				for (int j = 0; j < WinArea; j++) begin
					lt_s1[i][j] <= win[j*PixW +: PixW] < win[i*PixW +: PixW];
					eq_s1[i][j] <= (win[j*PixW +: PixW] == win[i*PixW +: PixW]) && (j < i);
				end
			end
		end
	end

	// Second stage: the element whose stable rank is the middle one is the median.
	always_comb begin
		for (int i = 0; i < WinArea; i++) begin
			hit[i] = (CntW'($countones(lt_s1[i])) + CntW'($countones(eq_s1[i])))
				== CntW'(Mid);
		end
		pick = '0;
		for (int i = 0; i < WinArea; i++) begin
			pick = pick | (val_s1[i] & {PixW{hit[i]}});
		end
	end

	// The rank decision is driven straight from the compare registers.
	assign med = pick;
endmodule
`default_nettype wire

// File: verif/mfw_checker.sv
// Checker for the median filter: watches every channel, predicts medians and compares them.
`default_nettype none
module mfw_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire logic [mfw_pkg::PixW-1:0]   pixel,
	input  wire logic                       frame_start,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire logic [mfw_pkg::PixW-1:0]   median_value,
	input  wire logic                       row_end,
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready,
	input  wire logic [mfw_pkg::WidthW-1:0] cfg_data,
	output int                              fails,
	output int                              pending
);
	import mfw_pkg::*;

	typedef struct {
		pix_t median;
		logic last;
	} median_beat_t;

	// Shadow copy of the filter state.
	entry_t              hist_rows [MaxLine];
	pix_t                win [WinSize][WinSize];
	logic [ColW-1:0]     col_pos;
	logic [RowW-1:0]     row_pos;
	logic [WidthW-1:0]   row_width;
	median_beat_t        median_q[$];
	int                  mismatches;

	// Middle element of the current window, found by insertion sort.
	function automatic pix_t window_middle();
		pix_t vals [WinArea];
		pix_t key;
		int   n;
		int   j;
		n = 0;
		for (int r = 0; r < WinSize; r++)
			for (int c = 0; c < WinSize; c++) begin
				vals[n] = win[r][c];
				n++;
			end
		for (int i = 1; i < WinArea; i++) begin
			key = vals[i];
			j = i - 1;
			while (j >= 0 && vals[j] > key) begin
				vals[j + 1] = vals[j];
				j--;
			end
			vals[j + 1] = key;
		end
		return vals[(WinArea - 1) / 2];
	endfunction

	// Advance the shadow state by one pixel and queue the median it yields.
	task automatic take_pixel(input pix_t px, input logic fs);
		int               eff;
		logic [AddrW-1:0] addr;
		entry_t           ent;
		logic             last;
		median_beat_t     mb;
		eff = int'(row_width);
		if (eff < WinSize) eff = WinSize;
		if (eff > MaxLine) eff = MaxLine;
		if (fs) begin
			col_pos = '0;
			row_pos = '0;
		end
		addr = col_pos;
		ent = hist_rows[addr];
		for (int r = 0; r < WinSize; r++)
			for (int c = 0; c < WinSize - 1; c++)
				win[r][c] = win[r][c + 1];
		for (int k = 0; k < HistRows; k++)
			win[k][WinSize - 1] = ent[PixW*k +: PixW];
		win[WinSize - 1][WinSize - 1] = px;
		hist_rows[addr] = {px, ent[EntryW-1:PixW]};
		last = int'(col_pos) >= eff - 1;
		if (int'(row_pos) >= HistRows && int'(col_pos) >= HistRows) begin
			mb.median = window_middle();
			mb.last = last;
			median_q.push_back(mb);
		end
		if (last) begin
			col_pos = '0;
			if (int'(row_pos) < HistRows) row_pos = row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	// Observe the channels on each rising edge.
	always @(posedge clk or negedge arst_n) begin
		median_beat_t mb;
		if (!arst_n) begin
			for (int a = 0; a < MaxLine; a++) hist_rows[a] = '0;
			for (int r = 0; r < WinSize; r++)
				for (int c = 0; c < WinSize; c++) win[r][c] = '0;
			col_pos = '0;
			row_pos = '0;
			row_width = WidthReset;
			median_q.delete();
			fails = 0;
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) row_width = cfg_data;
			if (in_valid && !in_stall) take_pixel(pixel, frame_start);
			if (out_valid && !out_stall) begin
				if (median_q.size() == 0) begin
					fails++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: median %0d row_end %0b",
							median_value, row_end);
				end else begin
					mb = median_q.pop_front();
					if (median_value !== mb.median || row_end !== mb.last) begin
						fails++;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: median exp %0d got %0d, row_end exp %0b got %0b",
								mb.median, median_value, mb.last, row_end);
					end
				end
			end
			pending = median_q.size();
		end
	end
endmodule
`default_nettype wire

// File: verif/tb_median_filter_window_unit.sv
// Testbench top for the median filter: clock, reset, stimulus and the final verdict.
`default_nettype none
module tb_median_filter_window_unit;
	import mfw_pkg::*;

	localparam int CycleLimit = 2000000;
	localparam int LongHold   = 300;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	pix_t              pixel;
	logic              frame_start;
	logic              out_valid;
	logic              out_stall;
	pix_t              median_value;
	logic              row_end;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [WidthW-1:0] cfg_data;
	int                fails;
	int                pending;

	logic in_took;
	logic cfg_took;
	logic calm;
	logic long_hold;
	int   hold_left;
	int   cycles;
	int   pixels_sent;
	int   eff_width;

	median_filter_window_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .frame_start(frame_start),
		.out_valid(out_valid), .out_stall(out_stall), .median_value(median_value),
		.row_end(row_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	mfw_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .frame_start(frame_start),
		.out_valid(out_valid), .out_stall(out_stall), .median_value(median_value),
		.row_end(row_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Note accepted beats for the driving processes, and guard against a hang.
	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		cfg_took <= cfg_valid && cfg_ready;
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (long_hold) begin
				long_hold = 1'b0;
				hold_left = LongHold;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 31);
			end
		end
	end

	// Offer one pixel beat, with random gaps before it.
	task automatic push_pixel(input pix_t px, input logic fs);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= px;
		frame_start <= fs;
		do @(negedge clk); while (!in_took);
		pixels_sent++;
	endtask

	// Wait for every expected median, then let the pipeline drain.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	// Write the row width while the block is idle.
	task automatic set_width(input logic [WidthW-1:0] w);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
		eff_width = (int'(w) < WinSize) ? WinSize : (int'(w) > MaxLine ? MaxLine : int'(w));
	endtask

	// Random pixel in one of several value styles.
	function automatic pix_t pick_pixel(input int style);
		case (style)
			0: return pix_t'($urandom_range(255));
			1: return pix_t'($urandom_range(140, 100));
			2: return $urandom_range(1) ? 8'hFF : 8'h00;
			default: return pix_t'($urandom_range(3) == 0 ? 255 : $urandom_range(9));
		endcase
	endfunction

	// Send a frame of the given size, with a rare restart mid-frame.
	task automatic send_frame(input int rows, input int tail);
		int style;
		style = $urandom_range(3);
		for (int i = 0; i < rows * eff_width + tail; i++)
			push_pixel(pick_pixel(style), (i == 0) || ($urandom_range(399) == 0));
	endtask

	initial begin
		int rows;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel = '0;
		frame_start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		calm = 1'b0;
		long_hold = 1'b0;
		cycles = 0;
		pixels_sent = 0;
		eff_width = int'(WidthReset);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a width below the minimum, one 5x5 frame of extreme values.
		set_width(12'd3);
		for (int i = 0; i < WinArea; i++)
			push_pixel((i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'h80), i == 0);
		set_width(12'd0);
		send_frame(6, 0);

		// Width cut mid-row: the current pixel then ends the row.
		set_width(12'd30);
		send_frame(6, 15);
		set_width(12'd10);
		for (int i = 0; i < 40; i++) push_pixel(pick_pixel(0), 1'b0);

		// Widest row, from a value beyond the maximum: a long row that must not end early.
		set_width(12'hFFF);
		send_frame(0, 200);

		// Random frames of mostly small widths.
		while (pixels_sent < 1300) begin
			rows = $urandom_range(9, 5);
			set_width(WidthW'($urandom_range(3) == 0 ? $urandom_range(64)
				: $urandom_range(12, 5)));
			calm = ($urandom_range(7) == 0);
			if ($urandom_range(9) == 0) long_hold = 1'b1;
			send_frame(rows, 0);
			calm = 1'b0;
		end

		// Receiver holds off while the sender keeps offering beats.
		set_width(12'd40);
		long_hold = 1'b1;
		send_frame(6, 0);

		drain();
		if (fails == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
